>>> hdl/vns_pkg.sv
// Package for the 2D vector normalise-and-scale block.
// Widths, register indexes and shared types; no dependencies.
package vns_pkg;
  localparam int unsigned CoordBits = 10;
  localparam int unsigned FracBits  = 8;
  localparam int unsigned SpeedBits = 5;
  localparam int unsigned VelBits   = 14;
  localparam int unsigned SqBits    = 2 * CoordBits + 1;
  localparam int unsigned RootBits  = (SqBits + 1) / 2;
  localparam int unsigned NumBits   = CoordBits + SpeedBits + FracBits;
  localparam int unsigned QuoBits   = NumBits;
  localparam int unsigned CfgIdxBits = 2;
  localparam int unsigned CfgDataBits = 16;
  localparam logic [SpeedBits-1:0] SpeedReset = SpeedBits'(18);

  typedef enum logic [CfgIdxBits-1:0] {
    CfgOriginX = 2'd0,
    CfgOriginY = 2'd1,
    CfgSpeed   = 2'd2
  } cfg_idx_e;

  typedef logic [CoordBits-1:0] coord_t;
  typedef logic signed [VelBits-1:0] vel_t;
endpackage

>>> hdl/vector_normalize_scale_2d.sv
// Top level: pipelined 2D vector normalise and scale.
// Depends on vns_pkg.
//
// Usage: pulse start with target_x_i/target_y_i while busy is low; busy
// is never raised, so one item may enter every cycle. cfg_valid_i with
// cfg_index_i/cfg_data_i writes origin_x (0), origin_y (1) or speed (2);
// cfg_ready_o is always high, other indexes are ignored. Write only when idle.
// Each item gives one result on velocity_x_o, velocity_y_o, zero_length_o,
// marked by done_o for one cycle; throughput is one item per cycle. Each
// item passes the difference stage, the square and numerator stage, the
// restoring square root (one result bit per stage), the restoring divider
// (one quotient bit per stage) and the output stage, in that order.
// The receiver cannot stall; results are never held back.
// Reset clears all valid bits and sets origin to 0, speed to 18.
module vector_normalize_scale_2d (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic [vns_pkg::CoordBits-1:0]      target_x_i,
  input  logic [vns_pkg::CoordBits-1:0]      target_y_i,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [vns_pkg::CfgIdxBits-1:0]     cfg_index_i,
  input  logic [vns_pkg::CfgDataBits-1:0]    cfg_data_i,
  output logic                               done_o,
  output logic signed [vns_pkg::VelBits-1:0] velocity_x_o,
  output logic signed [vns_pkg::VelBits-1:0] velocity_y_o,
  output logic                               zero_length_o
);
  import vns_pkg::*;

  localparam int unsigned RS = RootBits;
  localparam int unsigned DS = QuoBits;
  localparam int unsigned RemW = RootBits + 2;

  coord_t ox_q, oy_q;
  logic [SpeedBits-1:0] spd_q;

  assign busy = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ox_q <= '0;
      oy_q <= '0;
      spd_q <= SpeedReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgOriginX: ox_q <= cfg_data_i[CoordBits-1:0];
        CfgOriginY: oy_q <= cfg_data_i[CoordBits-1:0];
        CfgSpeed:   spd_q <= cfg_data_i[SpeedBits-1:0];
        default: ;
      endcase
    end
  end

  // stage 0: differences
  logic v0_q, nx0_q, ny0_q;
  coord_t mx0_q, my0_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v0_q <= 1'b0;
    else v0_q <= start;
  end
  always_ff @(posedge clk_i) begin
    nx0_q <= target_x_i < ox_q;
    ny0_q <= target_y_i < oy_q;
    mx0_q <= (target_x_i < ox_q) ? ox_q - target_x_i : target_x_i - ox_q;
    my0_q <= (target_y_i < oy_q) ? oy_q - target_y_i : target_y_i - oy_q;
  end

  // stage 1: squares and numerators
  logic v1_q, nx1_q, ny1_q;
  logic [SqBits-1:0] sq1_q;
  logic [NumBits-1:0] numx1_q, numy1_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else v1_q <= v0_q;
  end
  always_ff @(posedge clk_i) begin
    nx1_q <= nx0_q;
    ny1_q <= ny0_q;
    sq1_q <= SqBits'(mx0_q * mx0_q) + SqBits'(my0_q * my0_q);
    numx1_q <= {NumBits'(mx0_q * spd_q)} << FracBits;
    numy1_q <= {NumBits'(my0_q * spd_q)} << FracBits;
  end

  // square root: one result bit per stage
  logic [RS:1] sv_q;
  logic [RS:1][2*RS-1:0] srad_q;
  logic [RS:1][RemW-1:0] srem_q;
  logic [RS:1][RootBits-1:0] sroot_q;
  logic [RS:1][NumBits-1:0] snx_q, sny_q;
  logic [RS:1] snegx_q, snegy_q;

  for (genvar s = 0; s < RS; s++) begin : g_sqrt
    logic v_w, negx_w, negy_w;
    logic [2*RS-1:0] rad_w;
    logic [RemW-1:0] remi_w, rem_w, trial_w;
    logic [RootBits-1:0] root_w;
    logic [NumBits-1:0] nx_w, ny_w;
    if (s == 0) begin : g_in
      assign v_w = v1_q;
      assign rad_w = (2*RS)'(sq1_q);
      assign remi_w = '0;
      assign root_w = '0;
      assign nx_w = numx1_q;
      assign ny_w = numy1_q;
      assign negx_w = nx1_q;
      assign negy_w = ny1_q;
    end else begin : g_in
      assign v_w = sv_q[s];
      assign rad_w = srad_q[s];
      assign remi_w = srem_q[s];
      assign root_w = sroot_q[s];
      assign nx_w = snx_q[s];
      assign ny_w = sny_q[s];
      assign negx_w = snegx_q[s];
      assign negy_w = snegy_q[s];
    end
    assign rem_w = {remi_w[RemW-3:0], rad_w[2*RS-1 -: 2]};
    assign trial_w = {root_w, 2'b01};
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) sv_q[s+1] <= 1'b0;
      else sv_q[s+1] <= v_w;
    end
    always_ff @(posedge clk_i) begin
      srad_q[s+1] <= rad_w << 2;
      if (rem_w >= trial_w) begin
        srem_q[s+1] <= rem_w - trial_w;
        sroot_q[s+1] <= {root_w[RootBits-2:0], 1'b1};
      end else begin
        srem_q[s+1] <= rem_w;
        sroot_q[s+1] <= {root_w[RootBits-2:0], 1'b0};
      end
      snx_q[s+1] <= nx_w;
      sny_q[s+1] <= ny_w;
      snegx_q[s+1] <= negx_w;
      snegy_q[s+1] <= negy_w;
    end
  end

  // divider: both components, one quotient bit per stage
  logic [DS:1] dv_q;
  logic [DS:1][RootBits-1:0] dd_q;
  logic [DS:1][NumBits-1:0] dnx_q, dny_q;
  logic [DS:1][RootBits:0] drx_q, dry_q;
  logic [DS:1] dnegx_q, dnegy_q;

  for (genvar s = 0; s < DS; s++) begin : g_div
    logic v_w, negx_w, negy_w;
    logic [RootBits-1:0] d_w;
    logic [NumBits-1:0] nx_w, ny_w;
    logic [RootBits:0] rx_w, ry_w;
    logic [RootBits:0] px_w, py_w, dw;
    if (s == 0) begin : g_in
      assign v_w = sv_q[RS];
      assign d_w = sroot_q[RS];
      assign nx_w = snx_q[RS];
      assign ny_w = sny_q[RS];
      assign rx_w = '0;
      assign ry_w = '0;
      assign negx_w = snegx_q[RS];
      assign negy_w = snegy_q[RS];
    end else begin : g_in
      assign v_w = dv_q[s];
      assign d_w = dd_q[s];
      assign nx_w = dnx_q[s];
      assign ny_w = dny_q[s];
      assign rx_w = drx_q[s];
      assign ry_w = dry_q[s];
      assign negx_w = dnegx_q[s];
      assign negy_w = dnegy_q[s];
    end
    assign px_w = {rx_w[RootBits-1:0], nx_w[NumBits-1]};
    assign py_w = {ry_w[RootBits-1:0], ny_w[NumBits-1]};
    assign dw = {1'b0, d_w};
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dv_q[s+1] <= 1'b0;
      else dv_q[s+1] <= v_w;
    end
    always_ff @(posedge clk_i) begin
      dd_q[s+1] <= d_w;
      dnegx_q[s+1] <= negx_w;
      dnegy_q[s+1] <= negy_w;
      if (px_w >= dw) begin
        drx_q[s+1] <= px_w - dw;
        dnx_q[s+1] <= {nx_w[NumBits-2:0], 1'b1};
      end else begin
        drx_q[s+1] <= px_w;
        dnx_q[s+1] <= {nx_w[NumBits-2:0], 1'b0};
      end
      if (py_w >= dw) begin
        dry_q[s+1] <= py_w - dw;
        dny_q[s+1] <= {ny_w[NumBits-2:0], 1'b1};
      end else begin
        dry_q[s+1] <= py_w;
        dny_q[s+1] <= {ny_w[NumBits-2:0], 1'b0};
      end
    end
  end

  // output stage: saturate, sign, zero-length
  localparam logic [QuoBits-1:0] VelMax = QuoBits'((1 << (VelBits - 1)) - 1);

  function automatic vel_t sat(input logic neg, input logic [QuoBits-1:0] q);
    logic [QuoBits-1:0] m;
    begin
      if (neg) begin
        m = (q > VelMax + 1'b1) ? VelMax + 1'b1 : q;
        sat = vel_t'(-m[VelBits-1:0]);
      end else begin
        m = (q > VelMax) ? VelMax : q;
        sat = vel_t'(m[VelBits-1:0]);
      end
    end
  endfunction

  logic done_q, zl_q;
  vel_t vx_q, vy_q;
  logic zl_w;
  assign zl_w = (dd_q[DS] == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else done_q <= dv_q[DS];
  end
  always_ff @(posedge clk_i) begin
    zl_q <= zl_w;
    vx_q <= zl_w ? '0 : sat(dnegx_q[DS], dnx_q[DS]);
    vy_q <= zl_w ? '0 : sat(dnegy_q[DS], dny_q[DS]);
  end

  assign done_o = done_q;
  assign velocity_x_o = vx_q;
  assign velocity_y_o = vy_q;
  assign zero_length_o = zl_q;

`ifndef SYNTHESIS
  a_zero_vel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && zero_length_o |-> velocity_x_o == '0 && velocity_y_o == '0)
    else $error("zero length with nonzero velocity");
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q |-> ##(RS + DS + 1) done_o)
    else $error("item lost in pipeline");
  a_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");
`endif
endmodule

>>> tb/sv/tb_vector_normalize_scale_2d.sv
// Testbench for vector_normalize_scale_2d: drives target points, predicts the
// scaled velocity per item and checks each strobed result in order.
// Depends on vns_pkg and the DUT; self-contained otherwise.
module tb_vector_normalize_scale_2d;
  timeunit 1ns;
  timeprecision 1ps;
  import vns_pkg::*;

  localparam int unsigned Latency = RootBits + QuoBits + 3;
  localparam int unsigned WatchLimit = 2000;

  typedef struct packed {
    vel_t vx;
    vel_t vy;
    logic zero;
  } velocity_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  coord_t target_x_i = '0;
  coord_t target_y_i = '0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxBits-1:0] cfg_index_i = '0;
  logic [CfgDataBits-1:0] cfg_data_i = '0;
  logic done_o;
  vel_t velocity_x_o;
  vel_t velocity_y_o;
  logic zero_length_o;

  coord_t org_x = '0;
  coord_t org_y = '0;
  logic [SpeedBits-1:0] spd = SpeedReset;
  velocity_t pending_vel[$];
  int errors = 0;
  int quiet_cycles = 0;
  bit idle_on = 1'b1;

  vector_normalize_scale_2d DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [63:0] isqrt(logic [63:0] v);
    logic [63:0] r;
    r = 0;
    for (int b = 31; b >= 0; b--)
      if ((r | (64'd1 << b)) * (r | (64'd1 << b)) <= v) r |= 64'd1 << b;
    return r;
  endfunction

  function automatic vel_t scale_comp(bit neg, logic [63:0] mag, logic [63:0] len);
    logic [63:0] q;
    q = (mag * spd * (64'd1 << FracBits)) / len;
    if (neg) begin
      if (q > 8192) q = 8192;
      return vel_t'(-$signed(q));
    end
    if (q > 8191) q = 8191;
    return vel_t'(q);
  endfunction

  function automatic velocity_t predict_velocity(coord_t tx, coord_t ty);
    velocity_t v;
    logic [63:0] mx, my, len;
    mx = (tx < org_x) ? org_x - tx : tx - org_x;
    my = (ty < org_y) ? org_y - ty : ty - org_y;
    len = isqrt(mx * mx + my * my);
    if (len == 0) begin
      v = '{vx: '0, vy: '0, zero: 1'b1};
    end else begin
      v.vx = scale_comp(tx < org_x, mx, len);
      v.vy = scale_comp(ty < org_y, my, len);
      v.zero = 1'b0;
    end
    return v;
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_vel.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        velocity_t e;
        e = pending_vel.pop_front();
        if (velocity_x_o !== e.vx)
          report_mismatch($sformatf("vx %0d exp %0d", velocity_x_o, e.vx));
        if (velocity_y_o !== e.vy)
          report_mismatch($sformatf("vy %0d exp %0d", velocity_y_o, e.vy));
        if (zero_length_o !== e.zero)
          report_mismatch($sformatf("zero %0b exp %0b", zero_length_o, e.zero));
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || (cfg_valid_i && cfg_ready_o)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_target(coord_t tx, coord_t ty);
    while (idle_on && $urandom_range(99) < 33) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    target_x_i <= tx;
    target_y_i <= ty;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_vel.push_back(predict_velocity(tx, ty));
  endtask

  task automatic drain;
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_vel.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgDataBits-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      CfgOriginX: org_x = coord_t'(val);
      CfgOriginY: org_y = coord_t'(val);
      CfgSpeed:   spd = val[SpeedBits-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [CfgDataBits-1:0] ox, logic [CfgDataBits-1:0] oy,
                            logic [CfgDataBits-1:0] sp);
    drain();
    write_reg(CfgOriginX, ox);
    write_reg(CfgOriginY, oy);
    write_reg(CfgSpeed, sp);
  endtask

  task automatic test_directed;
    send_target(0, 0);
    send_target(1023, 1023);
    send_target(1023, 0);
    send_target(0, 1023);
    set_config(512, 300, 31);
    send_target(512, 300);
    send_target(0, 0);
    send_target(1023, 1023);
    send_target(513, 300);
    send_target(511, 299);
    send_target(512, 1023);
    send_target(0, 300);
    set_config(1023, 1023, 1);
    send_target(0, 0);
    send_target(1023, 1023);
    send_target(1022, 1023);
    set_config(16'hFFFF, 16'hFC00, 0);
    send_target(0, 0);
    send_target(1023, 1023);
    send_target(1, 2);
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      coord_t tx, ty;
      if ($urandom_range(9) == 0) begin
        tx = org_x; ty = org_y;
      end else if ($urandom_range(3) == 0) begin
        tx = coord_t'(org_x + $urandom_range(8) - 4);
        ty = coord_t'(org_y + $urandom_range(8) - 4);
      end else begin
        tx = coord_t'($urandom);
        ty = coord_t'($urandom);
      end
      send_target(tx, ty);
    end
  endtask

  task automatic test_configs;
    for (int p = 0; p < 5; p++) begin
      set_config(16'($urandom), 16'($urandom), 16'($urandom_range(31)));
      test_random(80);
    end
    set_config(0, 0, 18);
    test_random(40);
  endtask

  task automatic test_back_to_back;
    idle_on = 1'b0;
    test_random(60);
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_configs();
    test_back_to_back();
    drain();
    repeat (Latency + 5) @(posedge clk_i);
    if (errors == 0 && pending_vel.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

>>> vector_normalize_scale_2d.f
hdl/vns_pkg.sv
hdl/vector_normalize_scale_2d.sv
tb/sv/tb_vector_normalize_scale_2d.sv
